// ----- sv/tts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg: shared types, constants and text tables of the transcoder
// Character codes, the item and plan types, and the text pool from which
// the fixed strings of the script output are drawn.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned CharW    = 16;
  localparam int unsigned AheadW   = 2;
  localparam int unsigned RomDepth = 32;
  localparam int unsigned RomAw    = $clog2(RomDepth);
  localparam int unsigned LenW     = 5;
  localparam int unsigned NumSeg   = 4;
  localparam int unsigned SegCntW  = 3;
  localparam int unsigned SegPtrW  = $clog2(NumSeg);

  typedef logic [CharW-1:0]   char_t;
  typedef logic [AheadW-1:0]  ahead_t;
  typedef logic [RomAw-1:0]   rom_addr_t;
  typedef logic [LenW-1:0]    seg_len_t;
  typedef logic [SegPtrW-1:0] seg_ptr_t;

  // Character codes the parser looks for
  localparam char_t ChLt = char_t'(8'h3C);  // <
  localparam char_t ChQm = char_t'(8'h3F);  // ?
  localparam char_t ChGt = char_t'(8'h3E);  // >
  localparam char_t ChEq = char_t'(8'h3D);  // =
  localparam char_t ChSq = char_t'(8'h27);  // single quote
  localparam char_t ChDq = char_t'(8'h22);  // double quote
  localparam char_t ChBs = char_t'(8'h5C);  // backslash
  localparam char_t ChLf = char_t'(8'h0A);  // newline
  localparam char_t ChCr = char_t'(8'h0D);  // carriage return

  // Pieces of output text emitted for one item
  typedef enum logic [3:0] {
    SEG_NONE,
    SEG_OPEN,        // print call with opening quote
    SEG_EXPR,        // print call without quote
    SEG_NL,          // escaped newline and string restart
    SEG_END_LIT,     // close of a literal print call
    SEG_TRAILER,     // close of the stream in literal text
    SEG_CLOSE_EXPR,  // close of a print expression, then newline
    SEG_LF,          // bare newline
    SEG_QUOTE,       // escaped single quote
    SEG_BSLASH,      // escaped backslash
    SEG_CHAR         // the item's own character
  } seg_e;

  typedef struct packed {
    char_t  ch;
    char_t  next_ch;
    char_t  after_next_ch;
    ahead_t ahead_count;
  } item_t;

  typedef struct packed {
    seg_e [NumSeg-1:0]  seg;
    logic [SegCntW-1:0] nseg;
    char_t              ch;
  } plan_t;

  // Text pool; the strings overlap where one is a tail or head of another
  localparam logic [7:0] TextRom [RomDepth] = '{
    8'h4D, 8'h75, 8'h73, 8'h68, 8'h69, 8'h2E, 8'h63, 8'h6F,  //  0: open / expr
    8'h6E, 8'h6E, 8'h2E, 8'h70, 8'h72, 8'h69, 8'h6E, 8'h74,
    8'h28, 8'h27,
    8'h20,                                                   // 18: trailer
    8'h27, 8'h29, 8'h3B, 8'h0A,                              // 19: end of literal
    8'h5C, 8'h6E, 8'h27, 8'h2B, 8'h0A, 8'h27,                // 23: newline escape
    8'h5C, 8'h5C, 8'h27                                      // 29: backslash, quote
  };

  function automatic rom_addr_t seg_start(seg_e s);
    rom_addr_t a;
    unique case (s)
      SEG_OPEN,
      SEG_EXPR:       a = rom_addr_t'(0);
      SEG_TRAILER:    a = rom_addr_t'(18);
      SEG_END_LIT:    a = rom_addr_t'(19);
      SEG_CLOSE_EXPR: a = rom_addr_t'(20);
      SEG_LF:         a = rom_addr_t'(22);
      SEG_NL:         a = rom_addr_t'(23);
      SEG_BSLASH:     a = rom_addr_t'(29);
      SEG_QUOTE:      a = rom_addr_t'(30);
      default:        a = rom_addr_t'(0);
    endcase
    return a;
  endfunction

  function automatic seg_len_t seg_len(seg_e s);
    seg_len_t n;
    unique case (s)
      SEG_OPEN:       n = seg_len_t'(18);
      SEG_EXPR:       n = seg_len_t'(17);
      SEG_TRAILER:    n = seg_len_t'(5);
      SEG_END_LIT:    n = seg_len_t'(4);
      SEG_CLOSE_EXPR: n = seg_len_t'(3);
      SEG_NL:         n = seg_len_t'(6);
      SEG_BSLASH,
      SEG_QUOTE:      n = seg_len_t'(2);
      default:        n = seg_len_t'(1);
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tts_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tts_if: item channels of the transcoder
// Input channel carries one template character with lookahead; output
// channel carries one script character with an end-of-run flag.
// ----------------------------------------------------------------------------
interface tts_in_if import tts_pkg::*; ();
  logic   valid;
  logic   ready;
  char_t  ch;
  char_t  next_ch;
  char_t  after_next_ch;
  ahead_t ahead_count;

  modport source (output valid, output ch, output next_ch, output after_next_ch,
                  output ahead_count, input ready);
  modport sink   (input valid, input ch, input next_ch, input after_next_ch,
                  input ahead_count, output ready);
endinterface

interface tts_out_if import tts_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_ch;
  logic  run_last;

  modport source (output valid, output out_ch, output run_last, input ready);
  modport sink   (input valid, input out_ch, input run_last, output ready);
endinterface
`default_nettype wire

// ----- sv/tts_plan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tts_plan: parser state and output planning
// Holds the mode, quote and skip state, and turns one item into a short list
// of output text pieces. State advances when the item is taken.
// ----------------------------------------------------------------------------
module tts_plan import tts_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire item_t item_i,
  output plan_t      plan_o
);

  typedef struct packed {
    logic   started;
    logic   code_mode;
    logic   quote_open;
    char_t  quote_kind;
    logic   print_expr;
    ahead_t skip_left;
    char_t  previous_char;
  } st_t;

  st_t st_q, st_d;

  // Decide the next state and the pieces to emit
  always_comb begin
    seg_e               seg_pre, seg_b1, seg_b2, seg_tr;
    seg_e [NumSeg-1:0]  list;
    logic               handle;
    logic               near1, near2, near3;
    logic [SegCntW-1:0] cnt;

    st_d    = st_q;
    handle  = 1'b1;
    seg_pre = SEG_NONE;
    seg_b1  = SEG_NONE;
    seg_b2  = SEG_NONE;
    seg_tr  = SEG_NONE;
    near1   = (item_i.ahead_count != ahead_t'(0));
    near2   = item_i.ahead_count[1];
    near3   = &item_i.ahead_count;

    // Stream start or skipped mark characters
    if (!st_q.started) begin
      st_d.started = 1'b1;
      if (item_i.ch == ChLt && near1 && item_i.next_ch == ChQm) begin
        st_d.code_mode = 1'b1;
        st_d.skip_left = ahead_t'(1);
        handle         = 1'b0;
      end else begin
        st_d.code_mode = 1'b0;
        seg_pre        = SEG_OPEN;
      end
    end else if (st_q.skip_left != ahead_t'(0)) begin
      st_d.skip_left = st_q.skip_left - ahead_t'(1);
      handle         = 1'b0;
    end

    // Handle the character itself
    if (handle) begin
      if (!st_d.code_mode && item_i.ch == ChSq) begin
        seg_b1 = SEG_QUOTE;
      end else if (!st_d.code_mode && item_i.ch == ChLf) begin
        seg_b1 = SEG_NL;
      end else if (!st_d.code_mode && item_i.ch == ChBs) begin
        seg_b1 = SEG_BSLASH;
      end else if (st_d.code_mode && (item_i.ch == ChSq || item_i.ch == ChDq)) begin
        if (st_q.quote_open) begin
          if (item_i.ch == st_q.quote_kind && st_q.previous_char != ChBs) begin
            st_d.quote_open = 1'b0;
          end
        end else begin
          st_d.quote_open = 1'b1;
          st_d.quote_kind = item_i.ch;
        end
        seg_b1 = SEG_CHAR;
      end else if (item_i.ch == ChCr) begin
        seg_b1 = SEG_NONE;
      end else if (item_i.ch == ChLt && near2 && !st_d.code_mode &&
                   item_i.next_ch == ChQm) begin
        st_d.print_expr = 1'b0;
        st_d.code_mode  = 1'b1;
        st_d.quote_open = 1'b0;
        st_d.skip_left  = ahead_t'(1);
        seg_b1          = SEG_END_LIT;
        if (near3 && item_i.after_next_ch == ChEq) begin
          st_d.print_expr = 1'b1;
          st_d.skip_left  = ahead_t'(2);
          seg_b2          = SEG_EXPR;
        end
      end else if (item_i.ch == ChQm && !st_q.quote_open && near2 && st_d.code_mode &&
                   item_i.next_ch == ChGt) begin
        seg_b1         = st_q.print_expr ? SEG_CLOSE_EXPR : SEG_LF;
        seg_b2         = SEG_OPEN;
        st_d.code_mode = 1'b0;
        st_d.skip_left = ahead_t'(1);
      end else begin
        seg_b1 = SEG_CHAR;
      end
    end

    st_d.previous_char = item_i.ch;

    // Close the stream on its last item
    if (!near1) begin
      if (!st_d.code_mode) begin
        seg_tr = SEG_TRAILER;
      end
      st_d = '0;
    end

    // Pack the pieces to the front of the list
    list        = {NumSeg{SEG_NONE}};
    cnt         = '0;
    plan_o.seg  = {NumSeg{SEG_NONE}};
    list[0]     = seg_pre;
    list[1]     = seg_b1;
    list[2]     = seg_b2;
    list[3]     = seg_tr;
    for (int k = 0; k < NumSeg; k++) begin
      if (list[k] != SEG_NONE) begin
        plan_o.seg[cnt[SegPtrW-1:0]] = list[k];
        cnt = cnt + SegCntW'(1);
      end
    end
    plan_o.nseg = cnt;
    plan_o.ch   = item_i.ch;
  end

  // Hold state; advance when an item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/template_to_script_transcoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// template_to_script_transcoder_top: template text to script text
// Wraps literal text in print calls, passes code through and opens print
// expressions, one script character per output item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                                   | Handshake
//  in_i    | sink      | ch, next_ch, after_next_ch, ahead_count   | valid/ready
//  out_o   | source    | out_ch, run_last                          | valid/ready
//
//  An input item emitting k characters holds the output port for k output
//  items (k from 0 to 29); items emitting zero or one character go at one
//  per cycle unless out_o stalls; the rate is set by the single output port,
//  fed by the segment emitter; items pass input, plan and output registers.
//  Reset is asynchronous and clears parser state and all valid flags.
//  A stall on out_o backs up through the emitter to in_i.ready.
// ----------------------------------------------------------------------------
module template_to_script_transcoder_top import tts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tts_in_if.sink    in_i,
  tts_out_if.source out_o
);

  // Input register
  logic  a_valid_q, a_valid_d;
  item_t a_item_q;
  logic  in_ready, in_take, a_move;

  // Plan register and emitter position
  logic     b_valid_q, b_valid_d;
  plan_t    b_plan_q;
  seg_ptr_t b_ptr_q, b_ptr_d;
  seg_len_t b_idx_q, b_idx_d;
  plan_t    plan;
  seg_e     cur_seg;
  seg_len_t cur_len;
  char_t    cur_char;
  logic     last_in_seg, last_of_plan, b_adv, b_free;

  // Output register
  logic  c_valid_q, c_valid_d;
  char_t c_ch_q;
  logic  c_last_q;

  tts_plan u_plan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (a_move),
    .item_i (a_item_q),
    .plan_o (plan)
  );

  // Select the current character of the plan
  always_comb begin
    rom_addr_t addr;
    cur_seg      = b_plan_q.seg[b_ptr_q];
    cur_len      = seg_len(cur_seg);
    addr         = seg_start(cur_seg) + b_idx_q[RomAw-1:0];
    last_in_seg  = (b_idx_q == cur_len - seg_len_t'(1));
    last_of_plan = last_in_seg &&
                   ({1'b0, b_ptr_q} == b_plan_q.nseg - SegCntW'(1));
    if (cur_seg == SEG_CHAR) begin
      cur_char = b_plan_q.ch;
    end else begin
      cur_char = {{(CharW-8){1'b0}}, TextRom[addr]};
    end
  end

  // Handshake between the stages
  assign b_adv    = b_valid_q && (!c_valid_q || out_o.ready);
  assign b_free   = !b_valid_q || (b_adv && last_of_plan);
  assign a_move   = a_valid_q && b_free;
  assign in_ready = !a_valid_q || a_move;
  assign in_take  = in_i.valid && in_ready;

  // Next values of the control registers
  always_comb begin
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    b_ptr_d   = b_ptr_q;
    b_idx_d   = b_idx_q;
    c_valid_d = c_valid_q;

    if (in_take) begin
      a_valid_d = 1'b1;
    end else if (a_move) begin
      a_valid_d = 1'b0;
    end

    if (a_move) begin
      b_valid_d = (plan.nseg != SegCntW'(0));
      b_ptr_d   = '0;
      b_idx_d   = '0;
    end else if (b_adv) begin
      if (last_of_plan) begin
        b_valid_d = 1'b0;
      end else if (last_in_seg) begin
        b_ptr_d = b_ptr_q + seg_ptr_t'(1);
        b_idx_d = '0;
      end else begin
        b_idx_d = b_idx_q + seg_len_t'(1);
      end
    end

    if (b_adv) begin
      c_valid_d = 1'b1;
    end else if (out_o.ready) begin
      c_valid_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      b_ptr_q   <= '0;
      b_idx_q   <= '0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      b_ptr_q   <= b_ptr_d;
      b_idx_q   <= b_idx_d;
      c_valid_q <= c_valid_d;
    end
  end

  // Load payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_item_q.ch            <= in_i.ch;
      a_item_q.next_ch       <= in_i.next_ch;
      a_item_q.after_next_ch <= in_i.after_next_ch;
      a_item_q.ahead_count   <= in_i.ahead_count;
    end
    if (a_move) begin
      b_plan_q <= plan;
    end
    if (b_adv) begin
      c_ch_q   <= cur_char;
      c_last_q <= last_of_plan;
    end
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = c_valid_q;
  assign out_o.out_ch   = c_ch_q;
  assign out_o.run_last = c_last_q;

endmodule
`default_nettype wire

// ----- sv/tts_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tts_checker: port checks for the transcoder
// Watches the output channel: stall behaviour, reset and runs of characters.
// ----------------------------------------------------------------------------
module tts_checker import tts_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  out_valid_i,
  input wire logic  out_ready_i,
  input wire char_t out_ch_i,
  input wire logic  out_run_last_i
);

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ch_i) &&
                                    $stable(out_run_last_i))
    else $error("stalled output item changed");

  // Drop output valid while in reset
  a_out_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // Advance through a run without gaps
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_run_last_i |=> out_valid_i)
    else $error("gap inside a run of output characters");

endmodule

bind template_to_script_transcoder_top tts_checker u_tts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_ch_i       (out_o.out_ch),
  .out_run_last_i (out_o.run_last)
);
`default_nettype wire

// ----- verif/tb_tts_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tts_checker: scoreboard of the template transcoder
// Watches both channels, predicts the script characters of every accepted
// template item and compares each accepted output item against the oldest
// prediction. Hands the failure count and the number of waiting
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module tb_tts_checker import tts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tts_in_if    in_ch_i,
  tts_out_if   out_ch_i,
  input  logic done_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    char_t ch;
    logic  last;
  } script_char_t;

  // Object name at the head of every print call, held as raw bytes
  localparam logic [39:0] CallHead = 40'h4D_75_73_68_69;

  // Predicted script characters, oldest first
  script_char_t script_q[$];

  // Parser state of the transcoder as predicted here
  bit      in_stream;
  bit      in_code;
  bit      in_quote;
  char_t   quote_ch;
  bit      expr_block;
  logic [1:0] skip_cnt;
  char_t   prev_ch;

  int           mismatch_cnt;
  bit           done_seen;
  item_t        in_item;
  script_char_t want;

  function automatic void clear_parser();
    in_stream  = 1'b0;
    in_code    = 1'b0;
    in_quote   = 1'b0;
    quote_ch   = '0;
    expr_block = 1'b0;
    skip_cnt   = '0;
    prev_ch    = '0;
  endfunction

  function automatic void put_char(char_t c);
    script_char_t e;
    e.ch   = c;
    e.last = 1'b0;
    script_q.push_back(e);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char({8'h00, s[i]});
  endfunction

  // Print call head, with or without the opening quote of a literal
  function automatic void put_call(bit quoted);
    for (int k = 4; k >= 0; k--) put_char({8'h00, CallHead[8*k +: 8]});
    put_text(".conn.print(");
    if (quoted) put_char(ChSq);
  endfunction

  // Work out the script characters caused by one template item
  function automatic void transcode_item(item_t it);
    int unsigned  first;
    bit           consume;
    script_char_t tail;
    first   = script_q.size();
    consume = 1'b1;

    if (!in_stream) begin
      // stream opening straight into code swallows the open mark
      in_stream = 1'b1;
      if (it.ch == ChLt && it.ahead_count >= 1 && it.next_ch == ChQm) begin
        in_code = 1'b1;
        skip_cnt = 2'd1;
        consume = 1'b0;
      end else begin
        in_code = 1'b0;
        put_call(1'b1);
      end
    end else if (skip_cnt != 0) begin
      skip_cnt = skip_cnt - 2'd1;
      consume = 1'b0;
    end

    if (consume) begin
      if (!in_code && it.ch == ChSq) begin
        put_text("\\'");
      end else if (!in_code && it.ch == ChLf) begin
        put_text("\\n'+\n'");
      end else if (!in_code && it.ch == ChBs) begin
        put_text("\\\\");
      end else if (in_code && (it.ch == ChSq || it.ch == ChDq)) begin
        // track string literals in code; an escaped quote keeps it open
        if (in_quote) begin
          if (it.ch == quote_ch && prev_ch != ChBs) in_quote = 1'b0;
        end else begin
          in_quote = 1'b1;
          quote_ch = it.ch;
        end
        put_char(it.ch);
      end else if (it.ch == ChCr) begin
        // drop carriage returns everywhere
        consume = 1'b0;
      end else if (it.ch == ChLt && it.ahead_count >= 2 && !in_code &&
                   it.next_ch == ChQm) begin
        expr_block = 1'b0;
        in_code    = 1'b1;
        in_quote   = 1'b0;
        put_text("');\n");
        skip_cnt = 2'd1;
        if (it.ahead_count == 3 && it.after_next_ch == ChEq) begin
          expr_block = 1'b1;
          put_call(1'b0);
          skip_cnt = 2'd2;
        end
      end else if (it.ch == ChQm && !in_quote && it.ahead_count >= 2 && in_code &&
                   it.next_ch == ChGt) begin
        if (expr_block) put_text(");");
        put_char(ChLf);
        put_call(1'b1);
        in_code  = 1'b0;
        skip_cnt = 2'd1;
      end else begin
        put_char(it.ch);
      end
    end

    prev_ch = it.ch;

    // close the stream on its last item
    if (it.ahead_count == 0) begin
      if (!in_code) put_text(" ');\n");
      clear_parser();
    end

    // flag the final character of this item
    if (script_q.size() > first) begin
      tail = script_q.pop_back();
      tail.last = 1'b1;
      script_q.push_back(tail);
    end
  endfunction

  // Compare output items first, then predict from the input item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      script_q.delete();
      mismatch_cnt = 0;
      done_seen    = 1'b0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (script_q.size() == 0) begin
          $error("unexpected output item: out_ch=%h run_last=%b",
                 out_ch_i.out_ch, out_ch_i.run_last);
          mismatch_cnt++;
        end else begin
          want = script_q.pop_front();
          if (out_ch_i.out_ch !== want.ch) begin
            $error("out_ch mismatch: expected %h, got %h", want.ch, out_ch_i.out_ch);
            mismatch_cnt++;
          end
          if (out_ch_i.run_last !== want.last) begin
            $error("run_last mismatch: expected %b, got %b", want.last,
                   out_ch_i.run_last);
            mismatch_cnt++;
          end
        end
      end

      if (in_ch_i.valid && in_ch_i.ready) begin
        in_item.ch            = in_ch_i.ch;
        in_item.next_ch       = in_ch_i.next_ch;
        in_item.after_next_ch = in_ch_i.after_next_ch;
        in_item.ahead_count   = in_ch_i.ahead_count;
        transcode_item(in_item);
      end

      // anything still waiting at the end never arrived
      if (done_i && !done_seen) begin
        done_seen = 1'b1;
        if (script_q.size() != 0) begin
          $error("output items never received: %0d", script_q.size());
          mismatch_cnt++;
        end
      end

      fail_cnt_o <= mismatch_cnt;
      pending_o  <= script_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the template transcoder
// Feeds directed template streams, then random streams built from literal
// runs, code blocks, print expressions and string literals, mixed with
// broken noise items. Both channels idle at random; the output side once
// holds off for a long stretch and the input side lets the block drain
// after each phase and once mid-run. The checker beside the block compares.
// ----------------------------------------------------------------------------
module tb_top import tts_pkg::*; ();

  localparam int          RandItems   = 360;
  localparam int          LongHold    = 400;
  localparam int          DrainCycles = 16;
  localparam int unsigned LimitCycles = 1_000_000;

  logic clk_i;
  logic rst_ni;
  logic check_done;
  int   fail_cnt;
  int   pending;

  tts_in_if  in_if ();
  tts_out_if out_if ();

  template_to_script_transcoder_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tb_tts_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_if),
    .out_ch_i   (out_if),
    .done_i     (check_done),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // Template text waiting to be sent
  char_t text_q[$];
  int    items_sent  = 0;
  bit    tx_calm     = 1'b0;
  bit    rx_calm     = 1'b0;
  bit    rx_hold_req = 1'b0;

  // Clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Pick one template character, biased towards the ones the parser watches
  function automatic char_t pick_char();
    char_t c;
    case ($urandom_range(0, 13))
      0, 1, 2, 3: c = char_t'($urandom_range(32, 126));
      4:          c = char_t'($urandom);
      5:          c = ChLf;
      6:          c = ChCr;
      7:          c = ChBs;
      8:          c = ChSq;
      9:          c = ChDq;
      10:         c = ChLt;
      11:         c = ChQm;
      12:         c = ChGt;
      default:    c = ChEq;
    endcase
    return c;
  endfunction

  function automatic void add_literal();
    repeat ($urandom_range(0, 4)) text_q.push_back(pick_char());
  endfunction

  // Code run, sometimes with a string literal holding quotes and close marks
  function automatic void add_code();
    char_t q;
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 3) == 0) begin
        q = $urandom_range(0, 1) ? ChSq : ChDq;
        text_q.push_back(q);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: begin
              text_q.push_back(ChBs);
              text_q.push_back(q);
            end
            1: text_q.push_back(q == ChSq ? ChDq : ChSq);
            2: begin
              text_q.push_back(ChQm);
              text_q.push_back(ChGt);
            end
            default: text_q.push_back(pick_char());
          endcase
        end
        text_q.push_back(q);
      end else begin
        text_q.push_back(pick_char());
      end
    end
  endfunction

  // Template: literal runs alternating with code blocks, now and then one left open
  function automatic void make_template();
    if ($urandom_range(0, 3) == 0) begin
      text_q.push_back(ChLt);
      text_q.push_back(ChQm);
      add_code();
      text_q.push_back(ChQm);
      text_q.push_back(ChGt);
    end
    repeat ($urandom_range(1, 3)) begin
      add_literal();
      text_q.push_back(ChLt);
      text_q.push_back(ChQm);
      if ($urandom_range(0, 1)) text_q.push_back(ChEq);
      add_code();
      if ($urandom_range(0, 5) != 0) begin
        text_q.push_back(ChQm);
        text_q.push_back(ChGt);
      end
    end
    if ($urandom_range(0, 1)) add_literal();
    if (text_q.size() == 0) text_q.push_back(pick_char());
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.ch            <= it.ch;
    in_if.next_ch       <= it.next_ch;
    in_if.after_next_ch <= it.after_next_ch;
    in_if.ahead_count   <= it.ahead_count;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // Send the held text as one stream, lookahead filled from the text
  task automatic send_text();
    item_t it;
    int    n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      it.ch            = text_q[i];
      it.next_ch       = (i + 1 < n) ? text_q[i+1] : char_t'($urandom);
      it.after_next_ch = (i + 2 < n) ? text_q[i+2] : char_t'($urandom);
      it.ahead_count   = ahead_t'((n - 1 - i > 3) ? 3 : n - 1 - i);
      send_item(it);
    end
    text_q.delete();
  endtask

  // Items with lookahead that does not match the text, mostly ending a stream
  task automatic send_noise();
    item_t it;
    int    n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      it = item_t'({$urandom, $urandom});
      if ($urandom_range(0, 1)) it.ch = pick_char();
      if ($urandom_range(0, 1)) it.next_ch = pick_char();
      if (i == n - 1 && $urandom_range(0, 3) != 0) it.ahead_count = '0;
      send_item(it);
    end
  endtask

  // Stop offering and wait until every predicted character has arrived
  task automatic drain_wait();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Output side: random stalls, one long hold-off on request
  initial begin : receiver
    int w;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      w = rx_calm ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    end
  end

  // Bound the run
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < LimitCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    in_if.valid         <= 1'b0;
    in_if.ch            <= '0;
    in_if.next_ch       <= '0;
    in_if.after_next_ch <= '0;
    in_if.ahead_count   <= '0;
    check_done          <= 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stream opening in code: the equals sign is plain code here
    text_q = '{ChLt, ChQm, ChEq, char_t'("a"), ChQm, ChGt};
    send_text();
    // literal escapes, extreme codes, print expression with a string literal
    // holding an escaped quote and the other quote kind, then a close mark
    text_q = '{ChSq, ChBs, ChLf, ChCr, 16'hFFFF, 16'h0000, ChLt, ChQm, ChEq,
               ChDq, ChBs, ChDq, ChSq, ChDq, ChQm, ChGt, char_t'("q")};
    send_text();
    // open mark too near the end for the equals sign; stream ends in code
    text_q = '{char_t'("y"), ChLt, ChQm, ChEq};
    send_text();
    drain_wait();

    while (items_sent < RandItems) begin
      if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
      end else begin
        make_template();
        send_text();
      end
      // fill the block against a long output hold-off
      if (!hold_done && items_sent > 140) begin
        hold_done   = 1'b1;
        tx_calm     = 1'b1;
        rx_hold_req = 1'b1;
      end
      // let the block run dry once
      if (!pause_done && items_sent > 260) begin
        pause_done = 1'b1;
        drain_wait();
      end
    end

    drain_wait();
    repeat (DrainCycles) @(posedge clk_i);
    check_done <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
